>>> design/battery_voltage_monitor_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the battery voltage monitor
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_MONITOR_MACROS_SVH
`define BATTERY_VOLTAGE_MONITOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BVM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bvm: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BVM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bvm: next-cycle check failed");

// Condition must never be true.
`define BVM_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("bvm: forbidden condition seen");

`endif

>>> design/bvm_pkg.sv
// ---------------------------------------------------------------------------
// bvm_pkg
// Types, widths and constants shared by the battery voltage monitor files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bvm_pkg;

  localparam int ADC_W      = 12;
  localparam int MV_W       = 18;
  localparam int CELLS_W    = 5;
  localparam int RATIO_W    = 14;
  localparam int CHARGE_W   = 14;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Serial arithmetic unit widths.
  localparam int MUL_A_W   = 18;
  localparam int MUL_B_W   = 14;
  localparam int PROD_W    = 32;
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 18;

  localparam logic [ADC_W-1:0]    ADC_MAX         = 12'd4095;
  localparam logic [MUL_B_W-1:0]  PIN_REF_MV      = 14'd3300;
  localparam logic [MUL_B_W-1:0]  FULL_HUNDREDTHS = 14'd10000;
  localparam logic [MV_W-1:0]     MV_MAX          = 18'd262143;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_MV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_Q8    = 3'd4;

  // Configuration reset values.
  localparam logic [CELLS_W-1:0] CELL_COUNT_RST  = 5'd4;
  localparam logic [MV_W-1:0]    EMPTY_MV_RST    = 18'd13200;
  localparam logic [MV_W-1:0]    FULL_MV_RST     = 18'd16800;
  localparam logic [MV_W-1:0]    CRITICAL_MV_RST = 18'd12800;
  localparam logic [RATIO_W-1:0] RATIO_Q8_RST    = 14'd2816;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_AVG_DIV,
    S_PIN_MUL,
    S_PACK_MUL,
    S_CELL_DIV,
    S_CHG_MUL,
    S_CHG_DIV,
    S_EMIT
  } seq_state_t;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

>>> design/bvm_ifs.sv
// ---------------------------------------------------------------------------
// Battery monitor channels
// Valid/ready channels for samples, reports and register writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bvm_sample_if;
  import bvm_pkg::*;
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bvm_report_if;
  import bvm_pkg::*;
  logic                valid;
  logic                ready;
  logic [ADC_W-1:0]    avg_raw;
  logic [MV_W-1:0]     pack_mv;
  logic [MV_W-1:0]     per_cell_mv;
  logic [CHARGE_W-1:0] charge_hundredths;
  logic                is_critical;
  logic                is_low;
  logic                is_ok;
  logic [COUNT_W-1:0]  report_count;
  logic [COUNT_W-1:0]  critical_count;
  modport source (output valid, output avg_raw, output pack_mv, output per_cell_mv,
                  output charge_hundredths, output is_critical, output is_low,
                  output is_ok, output report_count, output critical_count,
                  input ready);
  modport sink   (input valid, input avg_raw, input pack_mv, input per_cell_mv,
                  input charge_hundredths, input is_critical, input is_low,
                  input is_ok, input report_count, input critical_count,
                  output ready);
endinterface

interface bvm_cfg_if;
  import bvm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/battery_voltage_monitor.sv
// ---------------------------------------------------------------------------
// battery_voltage_monitor
// Averages raw converter samples and reports pack voltage and charge state.
// ---------------------------------------------------------------------------
// Samples of 0 and of full scale are dropped from the sum but still count
// toward the group of SAMPLE_COUNT. The sample that closes a group starts
// the report computation, and no sample is taken until that report has been
// loaded into the output register. The computation runs on one bit-serial
// multiplier (one multiplier bit a cycle) and one bit-serial divider (one
// quotient bit a cycle): average, pin millivolts, pack millivolts, per-cell
// millivolts and, when the pack lies strictly between the empty and full
// levels, the charge product and quotient; otherwise the charge is clamped
// to 0 or 10000. The report is loaded once the last step is done and the
// output register is free. A finished report waits in the output register
// while the next group collects. Register writes are taken in any cycle
// and are used at the next report.
`timescale 1ns / 1ps
`default_nettype none
`include "battery_voltage_monitor_macros.svh"

module battery_voltage_monitor #(
  parameter int SAMPLE_COUNT = 16
) (
  input wire logic    clk,
  input wire logic    rst,
  bvm_sample_if.sink  sample,
  bvm_report_if.source report,
  bvm_cfg_if.sink     cfg
);
  import bvm_pkg::*;

  // The sum of a full group of in-range samples must fit without wrapping.
  localparam int SUM_W = $clog2(SAMPLE_COUNT * 4094 + 1);
  localparam int IDX_W = $clog2(SAMPLE_COUNT);

  // Configuration registers.
  logic [CELLS_W-1:0] cell_count;
  logic [MV_W-1:0]    empty_mv;
  logic [MV_W-1:0]    full_mv;
  logic [MV_W-1:0]    critical_mv;
  logic [RATIO_W-1:0] divider_ratio_q8;

  // Group accumulation.
  logic [IDX_W-1:0]   sample_index;
  logic [SUM_W-1:0]   accepted_sum;
  logic [SUM_W-1:0]   sum_total;
  logic [ADC_W-1:0]   sample_add;
  logic               sample_take;
  logic               group_end;

  // Report working registers.
  seq_state_t         state;
  seq_state_t         state_next;
  logic [ADC_W-1:0]   avg_raw;
  logic [MV_W-1:0]    pack_mv;
  logic [MV_W-1:0]    pack_sat;
  logic [MV_W-1:0]    per_cell_mv;
  logic [CHARGE_W-1:0] charge;
  logic [COUNT_W-1:0] reports_seen;
  logic [COUNT_W-1:0] criticals_seen;
  logic               is_critical;
  logic               is_low;
  logic               is_ok;
  logic               charge_zero;
  logic               charge_full;

  // Output register.
  logic               out_valid;
  logic               out_load;

  // Serial units.
  logic                 mul_start;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    mul_prod;
  unit_stat_t           mul_stat;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;
  unit_stat_t           div_stat;
  logic [CELLS_W-1:0]   cells_div;

  bvm_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  bvm_serial_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // ---- Configuration writes --------------------------------------------
  // Writes are always taken; an index past the last register is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count       <= CELL_COUNT_RST;
      empty_mv         <= EMPTY_MV_RST;
      full_mv          <= FULL_MV_RST;
      critical_mv      <= CRITICAL_MV_RST;
      divider_ratio_q8 <= RATIO_Q8_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CELL_COUNT:  cell_count       <= cfg.data[CELLS_W-1:0];
        REG_EMPTY_MV:    empty_mv         <= cfg.data[MV_W-1:0];
        REG_FULL_MV:     full_mv          <= cfg.data[MV_W-1:0];
        REG_CRITICAL_MV: critical_mv      <= cfg.data[MV_W-1:0];
        REG_RATIO_Q8:    divider_ratio_q8 <= cfg.data[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---- Sample accumulation ---------------------------------------------
  // Readings at either rail are treated as outliers and add nothing.
  assign sample_take = sample.valid && sample.ready;
  assign sample_add  = ((sample.adc_sample != '0) && (sample.adc_sample != ADC_MAX))
                       ? sample.adc_sample : '0;
  assign sum_total   = accepted_sum + SUM_W'(sample_add);
  assign group_end   = (sample_index == IDX_W'(SAMPLE_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      accepted_sum <= '0;
    end else if (sample_take) begin
      if (group_end) begin
        sample_index <= '0;
        accepted_sum <= '0;
      end else begin
        sample_index <= sample_index + IDX_W'(1);
        accepted_sum <= sum_total;
      end
    end
  end

  // ---- Report datapath --------------------------------------------------
  // The pack value is the Q8 product shifted down by eight; any bit above
  // the 18-bit range means it saturates.
  assign pack_sat    = (|mul_prod[PROD_W-1:MV_W+8]) ? MV_MAX : mul_prod[MV_W+7:8];
  assign cells_div   = (cell_count == '0) ? CELLS_W'(1) : cell_count;
  assign charge_zero = (pack_mv <= empty_mv);
  assign charge_full = (pack_mv >= full_mv);
  assign is_critical = (pack_mv <= critical_mv);
  assign is_low      = (pack_mv <= empty_mv);
  assign is_ok       = (pack_mv > empty_mv) && (pack_mv <= full_mv);
  assign out_load    = (state == S_EMIT) && (!out_valid || report.ready);

  // ---- Sequencer: next state -------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_COLLECT:  if (sample_take && group_end) state_next = S_AVG_DIV;
      S_AVG_DIV:  if (div_stat.done) state_next = S_PIN_MUL;
      S_PIN_MUL:  if (mul_stat.done) state_next = S_PACK_MUL;
      S_PACK_MUL: if (mul_stat.done) state_next = S_CELL_DIV;
      S_CELL_DIV: begin
        if (div_stat.done) begin
          state_next = (charge_zero || charge_full) ? S_EMIT : S_CHG_MUL;
        end
      end
      S_CHG_MUL:  if (mul_stat.done) state_next = S_CHG_DIV;
      S_CHG_DIV:  if (div_stat.done) state_next = S_EMIT;
      S_EMIT:     if (out_load) state_next = S_COLLECT;
      default:    state_next = S_COLLECT;
    endcase
  end

  // ---- Sequencer: unit launches ----------------------------------------
  // Each step starts the next unit in the cycle where the previous one
  // reports done, straight from its held result.
  always_comb begin
    sample.ready = 1'b0;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = '0;
    unique case (state)
      S_COLLECT: begin
        sample.ready = 1'b1;
        div_start    = sample_take && group_end;
        div_num      = DIV_NUM_W'(sum_total);
        div_den      = DIV_DEN_W'(SAMPLE_COUNT);
      end
      S_AVG_DIV: begin
        mul_start = div_stat.done;
        mul_a     = MUL_A_W'(div_quo[ADC_W-1:0]);
        mul_b     = PIN_REF_MV;
      end
      S_PIN_MUL: begin
        mul_start = mul_stat.done;
        mul_a     = MUL_A_W'(mul_prod[2*ADC_W-1:ADC_W]);
        mul_b     = MUL_B_W'(divider_ratio_q8);
      end
      S_PACK_MUL: begin
        div_start = mul_stat.done;
        div_num   = DIV_NUM_W'(pack_sat);
        div_den   = DIV_DEN_W'(cells_div);
      end
      S_CELL_DIV: begin
        mul_start = div_stat.done && !charge_zero && !charge_full;
        mul_a     = pack_mv - empty_mv;
        mul_b     = FULL_HUNDREDTHS;
      end
      S_CHG_MUL: begin
        div_start = mul_stat.done;
        div_num   = mul_prod;
        div_den   = full_mv - empty_mv;
      end
      S_CHG_DIV, S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // ---- Working registers -----------------------------------------------
  always_ff @(posedge clk) begin
    if ((state == S_AVG_DIV) && div_stat.done) begin
      avg_raw <= div_quo[ADC_W-1:0];
    end
    if ((state == S_PACK_MUL) && mul_stat.done) begin
      pack_mv <= pack_sat;
    end
    if ((state == S_CELL_DIV) && div_stat.done) begin
      per_cell_mv <= div_quo[MV_W-1:0];
      if (charge_zero) begin
        charge <= '0;
      end else if (charge_full) begin
        charge <= FULL_HUNDREDTHS;
      end
    end
    if ((state == S_CHG_DIV) && div_stat.done) begin
      charge <= div_quo[CHARGE_W-1:0];
    end
  end

  // ---- Report counters and output register -----------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      reports_seen   <= '0;
      criticals_seen <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_load) begin
        reports_seen <= reports_seen + COUNT_W'(1);
        if (is_critical) begin
          criticals_seen <= criticals_seen + COUNT_W'(1);
        end
        out_valid <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      report.avg_raw           <= avg_raw;
      report.pack_mv           <= pack_mv;
      report.per_cell_mv       <= per_cell_mv;
      report.charge_hundredths <= charge;
      report.is_critical       <= is_critical;
      report.is_low            <= is_low;
      report.is_ok             <= is_ok;
      report.report_count      <= reports_seen + COUNT_W'(1);
      report.critical_count    <= criticals_seen + COUNT_W'(is_critical);
    end
  end

  assign report.valid = out_valid;

  // ---- Checks -----------------------------------------------------------
  // The multiplier and divider are chained, never run together.
  `BVM_ASSERT_NEVER(a_units_exclusive, clk, rst, mul_stat.busy && div_stat.busy)
  // A divider result only arrives in a state that waits for one.
  `BVM_ASSERT_IMP(a_div_done_state, clk, rst, div_stat.done,
    (state == S_AVG_DIV) || (state == S_CELL_DIV) || (state == S_CHG_DIV))
  // A loaded report carries the updated report counter.
  `BVM_ASSERT_NEXT(a_count_follows, clk, rst, out_load,
    report.valid && (report.report_count == reports_seen))
  // Charge never leaves its clamped range.
  `BVM_ASSERT_IMP(a_charge_range, clk, rst, report.valid,
    report.charge_hundredths <= FULL_HUNDREDTHS)

endmodule

`default_nettype wire

>>> design/bvm_serial_mul.sv
// ---------------------------------------------------------------------------
// bvm_serial_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bvm_serial_mul (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [bvm_pkg::MUL_A_W-1:0]  a,
  input  wire logic [bvm_pkg::MUL_B_W-1:0]  b,
  output logic      [bvm_pkg::PROD_W-1:0]   prod,
  output bvm_pkg::unit_stat_t               stat
);
  import bvm_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W + 1);

  logic [PROD_W-1:0]  mcand;
  logic [MUL_B_W-1:0] mplier;
  logic [CNT_W-1:0]   count;
  logic               done;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (count == CNT_W'(1));
      if (start) begin
        count <= CNT_W'(MUL_B_W);
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= PROD_W'(a);
      mplier <= b;
      prod   <= '0;
    end else if (count != '0) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= {mcand[PROD_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[MUL_B_W-1:1]};
    end
  end

  assign stat.busy = (count != '0);
  assign stat.done = done;

endmodule

`default_nettype wire

>>> design/bvm_serial_div.sv
// ---------------------------------------------------------------------------
// bvm_serial_div
// Restoring divider, one quotient bit per cycle, most significant first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bvm_serial_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [bvm_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [bvm_pkg::DIV_DEN_W-1:0]  den,
  output logic      [bvm_pkg::DIV_NUM_W-1:0]  quo,
  output bvm_pkg::unit_stat_t                 stat
);
  import bvm_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] divisor;
  logic [CNT_W-1:0]     count;
  logic                 done;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // The quotient register shifts the numerator out at the top while
  // quotient bits come in at the bottom.
  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (count == CNT_W'(1));
      if (start) begin
        count <= CNT_W'(DIV_NUM_W);
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= num;
      divisor <= den;
      rem     <= '0;
    end else if (count != '0) begin
      if (fits) begin
        rem <= DIV_DEN_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DIV_DEN_W-1:0];
      end
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  assign stat.busy = (count != '0);
  assign stat.done = done;

endmodule

`default_nettype wire
